[hdl/gmod_pkg.sv]
// shared types, constants and helpers of the gf/mw outlier detector
package gmod_pkg;

	localparam int SlotBits  = 6;
	localparam int IdxBits   = SlotBits + 1;
	localparam int AllSlots  = 2 * (1 << SlotBits);
	localparam int ValBits   = 48;
	localparam int CoefBits  = 31;
	localparam int CoefFrac  = 30;
	localparam int CntBits   = 16;
	localparam int DvdBits   = 65;
	localparam int DivCntBits = 7;

	// q30 constants indexed by constellation: wide-lane wavelength, code weights
	localparam logic [CoefBits-1:0] LW_Q30 [2] = '{31'd925477835, 31'd1100218408};
	localparam logic [CoefBits-1:0] C1_Q30 [2] = '{31'd603489930, 31'd592382505};
	localparam logic [CoefBits-1:0] C2_Q30 [2] = '{31'd470251894, 31'd481359319};

	localparam logic [1:0] REG_GF_LIMIT   = 2'd0;
	localparam logic [1:0] REG_MW_LIMIT   = 2'd1;
	localparam logic [1:0] REG_ZERO_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		VERD_INCOMPLETE = 2'd0,
		VERD_NO_ENTRY   = 2'd1,
		VERD_ACCEPTED   = 2'd2,
		VERD_REJECTED   = 2'd3
	} verdict_t;

	// item leaving the front pipeline
	typedef struct packed {
		logic                       valid;
		logic                       sys;
		logic [IdxBits-1:0]         idx;
		logic                       last;
		logic                       incomplete;
		logic signed [ValBits-1:0]  gf;
		logic signed [ValBits-1:0]  mw;
	} front_item_t;

	function automatic logic [ValBits-1:0] mag48(input logic signed [ValBits-1:0] v);
		mag48 = v[ValBits-1] ? (~v + 48'd1) : v;
	endfunction

	function automatic logic signed [ValBits-1:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -64'sh0000_8000_0000_0000;
		if (v > hi)
			sat48 = hi[ValBits-1:0];
		else if (v < lo)
			sat48 = lo[ValBits-1:0];
		else
			sat48 = v[ValBits-1:0];
	endfunction

endpackage

[hdl/gmod_obs_if.sv]
// request channels: observation in, verdict out
interface gmod_obs_if (input logic clk);
	logic                                        valid;
	logic                                        ready;
	logic                                        sat_system;
	logic [gmod_pkg::SlotBits-1:0]               sat_number;
	logic signed [gmod_pkg::ValBits-1:0]         code_first;
	logic signed [gmod_pkg::ValBits-1:0]         code_second;
	logic signed [gmod_pkg::ValBits-1:0]         phase_first;
	logic signed [gmod_pkg::ValBits-1:0]         phase_second;
	logic                                        epoch_last;
	modport source (input clk, output valid, sat_system, sat_number, code_first,
		code_second, phase_first, phase_second, epoch_last, input ready);
	modport sink (input clk, input valid, sat_system, sat_number, code_first,
		code_second, phase_first, phase_second, epoch_last, output ready);
endinterface

interface gmod_res_if (input logic clk);
	logic                                        valid;
	logic                                        ready;
	logic                                        usable;
	logic [1:0]                                  verdict;
	logic signed [gmod_pkg::ValBits-1:0]         gf_value;
	logic signed [gmod_pkg::ValBits-1:0]         mw_average;
	logic [gmod_pkg::CntBits-1:0]                track_count;
	modport source (input clk, output valid, usable, verdict, gf_value, mw_average,
		track_count, input ready);
	modport sink (input clk, input valid, usable, verdict, gf_value, mw_average,
		track_count, output ready);
endinterface

[hdl/gmod_front.sv]
// three-stage pipeline forming the geometry-free and melbourne-wubbena values
module gmod_front (
	input  logic                     clk,
	input  logic                     arst_n,
	gmod_obs_if.sink                 obs,
	input  logic [15:0]              zero_limit,
	input  logic                     take,
	output gmod_pkg::front_item_t    item
);
	localparam int VB = gmod_pkg::ValBits;
	localparam int CF = gmod_pkg::CoefFrac;

	// stage 1 registers
	logic          v_s1, sys_s1, last_s1, inc_s1;
	logic [gmod_pkg::IdxBits-1:0] idx_s1;
	logic signed [VB-1:0] gf_s1;
	logic [VB:0]   mx_s1;
	logic [VB-1:0] m1_s1, m2_s1;
	logic          sx_s1, sp1_s1, sp2_s1;
	// stage 2 registers
	logic          v_s2, sys_s2, last_s2, inc_s2;
	logic [gmod_pkg::IdxBits-1:0] idx_s2;
	logic signed [VB-1:0] gf_s2;
	logic [49:0]   hx_s2;
	logic [48:0]   h1_s2, h2_s2;
	logic [60:0]   lx_s2, l1_s2, l2_s2;
	logic          sx_s2, sp1_s2, sp2_s2;
	// stage 3 registers
	logic          v_s3, sys_s3, last_s3, inc_s3;
	logic [gmod_pkg::IdxBits-1:0] idx_s3;
	logic signed [VB-1:0] gf_s3, mw_s3;

	logic rdy1, rdy2, rdy3;
	logic signed [VB:0] dgf, dx;
	logic inc_c;
	logic signed [63:0] rx, r1, r2, mw_c;

	assign rdy3 = !v_s3 || take;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign obs.ready = rdy1;

	always_comb begin
		dgf = {obs.code_first[VB-1], obs.code_first} - {obs.code_second[VB-1], obs.code_second};
		dx = {obs.phase_first[VB-1], obs.phase_first} -
			{obs.phase_second[VB-1], obs.phase_second};
		inc_c = (gmod_pkg::mag48(obs.code_first) < {32'd0, zero_limit}) ||
			(gmod_pkg::mag48(obs.code_second) < {32'd0, zero_limit}) ||
			(gmod_pkg::mag48(obs.phase_first) < {32'd0, zero_limit}) ||
			(gmod_pkg::mag48(obs.phase_second) < {32'd0, zero_limit});
	end

	// rounded product magnitude, sign applied
	function automatic logic signed [63:0] rnd(input logic [49:0] hi, input logic [60:0] lo,
			input logic neg);
		logic [63:0] r;
		r = {14'd0, hi} + {33'd0, 31'((({3'd0, lo} + 64'd536870912) >> CF))};
		rnd = neg ? -$signed(r) : $signed(r);
	endfunction

	always_comb begin
		rx = rnd(hx_s2, lx_s2, sx_s2);
		r1 = rnd({1'b0, h1_s2}, l1_s2, sp1_s2);
		r2 = rnd({1'b0, h2_s2}, l2_s2, sp2_s2);
		mw_c = rx - (r1 + r2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= obs.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sys_s1  <= obs.sat_system;
			idx_s1  <= {obs.sat_system, obs.sat_number};
			last_s1 <= obs.epoch_last;
			inc_s1  <= inc_c;
			gf_s1   <= gmod_pkg::sat48(64'(dgf));
			sx_s1   <= dx[VB];
			mx_s1   <= dx[VB] ? 49'(-dx) : 49'(dx);
			sp1_s1  <= obs.code_first[VB-1];
			m1_s1   <= gmod_pkg::mag48(obs.code_first);
			sp2_s1  <= obs.code_second[VB-1];
			m2_s1   <= gmod_pkg::mag48(obs.code_second);
		end
		if (rdy2) begin
			sys_s2  <= sys_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			inc_s2  <= inc_s1;
			gf_s2   <= gf_s1;
			sx_s2   <= sx_s1;
			sp1_s2  <= sp1_s1;
			sp2_s2  <= sp2_s1;
			hx_s2   <= mx_s1[VB:CF] * gmod_pkg::LW_Q30[sys_s1];
			lx_s2   <= mx_s1[CF-1:0] * gmod_pkg::LW_Q30[sys_s1];
			h1_s2   <= m1_s1[VB-1:CF] * gmod_pkg::C1_Q30[sys_s1];
			l1_s2   <= m1_s1[CF-1:0] * gmod_pkg::C1_Q30[sys_s1];
			h2_s2   <= m2_s1[VB-1:CF] * gmod_pkg::C2_Q30[sys_s1];
			l2_s2   <= m2_s1[CF-1:0] * gmod_pkg::C2_Q30[sys_s1];
		end
		if (rdy3) begin
			sys_s3  <= sys_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			inc_s3  <= inc_s2;
			gf_s3   <= gf_s2;
			mw_s3   <= gmod_pkg::sat48(mw_c);
		end
	end

	always_comb begin
		item.valid      = v_s3;
		item.sys        = sys_s3;
		item.idx        = idx_s3;
		item.last       = last_s3;
		item.incomplete = inc_s3;
		item.gf         = gf_s3;
		item.mw         = mw_s3;
	end

endmodule

[hdl/gnss_gf_mw_outlier_detector_core.sv]
// top level of the gf/mw cycle-slip and outlier detector
//
// usage:
//   obs (sink) takes one dual-frequency observation per request; res (source)
//   gives one verdict request per observation, in order.
//   the cfg port (cfg_we, cfg_idx, cfg_wdata) writes gf_limit, mw_limit and
//   zero_limit; write only while no observation is in flight.
// flow:
//   three front stages form gf and mw; then a per-item track unit reads the
//   satellite entry, and on an accepted item forms the running sum and
//   divides it in a bit-serial restoring divider. the unit holds one item
//   at a time and takes no new item until its result has left the done
//   state; an incomplete item goes straight to done. the front stages keep
//   accepting while the unit is busy, until full.
// reset:
//   limits return to their defaults and all seen bits clear; the track
//   memories are not cleared, since a slot's stored values are only used once it has been seen.
// stall:
//   a held result stays in the output register; the unit waits in its done
//   state and the front pipeline fills and then drops obs.ready.
module gnss_gf_mw_outlier_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	gmod_obs_if.sink    obs,
	gmod_res_if.source  res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	localparam int VB = gmod_pkg::ValBits;
	localparam int NS = gmod_pkg::AllSlots;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// configuration
	logic [31:0] gf_limit_q, mw_limit_q;
	logic [15:0] zero_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gf_limit_q   <= 32'd13107;
			mw_limit_q   <= 32'd65536;
			zero_limit_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gmod_pkg::REG_GF_LIMIT:   gf_limit_q   <= cfg_wdata;
				gmod_pkg::REG_MW_LIMIT:   mw_limit_q   <= cfg_wdata;
				gmod_pkg::REG_ZERO_LIMIT: zero_limit_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// front pipeline
	gmod_pkg::front_item_t item;
	logic take;
	state_t state_q;

	assign take = item.valid && (state_q == ST_IDLE);

	gmod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.obs        (obs),
		.zero_limit (zero_limit_q),
		.take       (take),
		.item       (item)
	);

	// per-satellite track memories
	logic signed [VB-1:0] gf_mem [NS];
	logic signed [VB-1:0] mw_mem [NS];
	logic [15:0]          cnt_mem [NS];
	logic signed [VB-1:0] old_gf_q, old_mw_q;
	logic [15:0]          old_cnt_q;
	logic [NS-1:0]        seen_now_q, seen_before_q;

	// item held in the track unit
	logic [gmod_pkg::IdxBits-1:0] idx_q;
	logic                 last_q, inc_q;
	logic signed [VB-1:0] gf_q, mw_q;
	gmod_pkg::verdict_t   verd_q;
	logic [15:0]          cnt_q;

	// running-mean divider
	logic [63:0]          sum_q;
	logic                 neg_q;
	logic [gmod_pkg::DvdBits-1:0] dvd_q;
	logic [gmod_pkg::DvdBits-1:0] quo_q;
	logic [17:0]          rem_q;
	logic [16:0]          den_q;
	logic [gmod_pkg::DivCntBits-1:0] dcnt_q;

	logic done_go, res_free;
	logic signed [VB:0] dgf_c, dmw_c;
	logic [VB:0] agf_c, amw_c;
	logic pass_c, known_c;
	logic [17:0] rtry_c;
	logic [63:0] smag_c;
	logic signed [VB-1:0] qsig_c;

	assign res_free = !res.valid || res.ready;
	assign done_go  = (state_q == ST_DONE) && res_free;

	always_comb begin
		dgf_c   = {gf_q[VB-1], gf_q} - {old_gf_q[VB-1], old_gf_q};
		dmw_c   = {mw_q[VB-1], mw_q} - {old_mw_q[VB-1], old_mw_q};
		agf_c   = dgf_c[VB] ? 49'(-dgf_c) : 49'(dgf_c);
		amw_c   = dmw_c[VB] ? 49'(-dmw_c) : 49'(dmw_c);
		known_c = seen_now_q[idx_q] || seen_before_q[idx_q];
		pass_c  = (agf_c < {17'd0, gf_limit_q}) && (amw_c < {17'd0, mw_limit_q});
		rtry_c  = {rem_q[16:0], dvd_q[gmod_pkg::DvdBits-1]};
		smag_c  = sum_q[63] ? (~sum_q + 64'd1) : sum_q;
		qsig_c  = neg_q ? -$signed(quo_q[VB-1:0]) : $signed(quo_q[VB-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			seen_now_q    <= '0;
			seen_before_q <= '0;
			dcnt_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (take) state_q <= item.incomplete ? ST_DONE : ST_READ;
				ST_READ:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= (known_c && pass_c) ? ST_MUL : ST_DONE;
				ST_MUL: begin
					state_q <= ST_DIV;
					dcnt_q  <= '0;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'(gmod_pkg::DvdBits - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
						// epoch roll-over after this item's own marking
						if (last_q) begin
							seen_before_q <= inc_q ? seen_now_q
								: (seen_now_q | (NS'(1) << idx_q));
							seen_now_q    <= '0;
						end else if (!inc_q) begin
							seen_now_q[idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q  <= item.idx;
			last_q <= item.last;
			inc_q  <= item.incomplete;
			gf_q   <= item.gf;
			mw_q   <= item.mw;
			verd_q <= gmod_pkg::VERD_INCOMPLETE;
			cnt_q  <= 16'd0;
		end
		if (state_q == ST_READ) begin
			old_gf_q  <= gf_mem[idx_q];
			old_mw_q  <= mw_mem[idx_q];
			old_cnt_q <= cnt_mem[idx_q];
		end
		if (state_q == ST_CHECK) begin
			cnt_q  <= 16'd1;
			verd_q <= !known_c ? gmod_pkg::VERD_NO_ENTRY
				: (pass_c ? gmod_pkg::VERD_ACCEPTED : gmod_pkg::VERD_REJECTED);
		end
		if (state_q == ST_MUL) begin
			// n*old + mw, wraps in 64 bits as the sum of signed values
			sum_q <= ($signed({1'b0, old_cnt_q}) * 64'(old_mw_q)) + 64'(mw_q);
			den_q <= {1'b0, old_cnt_q} + 17'd1;
			cnt_q <= (old_cnt_q == 16'hFFFF) ? 16'hFFFF : old_cnt_q + 16'd1;
		end
		if (state_q == ST_DIV) begin
			if (dcnt_q == '0) begin
				neg_q <= sum_q[63];
				// dividend sits one place up so the 64 shifts reach its low bit
				dvd_q <= {smag_c + {48'd0, den_q[16:1]}, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				dvd_q <= {dvd_q[gmod_pkg::DvdBits-2:0], 1'b0};
				if (rtry_c >= {1'b0, den_q}) begin
					rem_q <= rtry_c - {1'b0, den_q};
					quo_q <= {quo_q[gmod_pkg::DvdBits-2:0], 1'b1};
				end else begin
					rem_q <= rtry_c;
					quo_q <= {quo_q[gmod_pkg::DvdBits-2:0], 1'b0};
				end
			end
		end
		if (done_go && !inc_q) begin
			gf_mem[idx_q]  <= gf_q;
			mw_mem[idx_q]  <= (verd_q == gmod_pkg::VERD_ACCEPTED) ? qsig_c : mw_q;
			cnt_mem[idx_q] <= cnt_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (done_go) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			res.usable      <= (verd_q == gmod_pkg::VERD_ACCEPTED);
			res.verdict     <= verd_q;
			res.gf_value    <= inc_q ? '0 : gf_q;
			res.mw_average  <= inc_q ? '0
				: ((verd_q == gmod_pkg::VERD_ACCEPTED) ? qsig_c : mw_q);
			res.track_count <= cnt_q;
		end
	end

	// the divider's load step and its shifts must end in done, so its counter never passes the last shift
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dcnt_q <= 7'(gmod_pkg::DvdBits - 1)))
		else $error("divider ran past its length");

	// a result is produced only from the done state
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == ST_DONE))
		else $error("result without a finished item");

	// an accepted verdict always reports usable and a nonzero count
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.verdict == gmod_pkg::VERD_ACCEPTED) |->
			(res.usable && res.track_count != 16'd0))
		else $error("accepted result inconsistent");

	// incomplete items never reach the memory read
	a_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !inc_q)
		else $error("incomplete item read the track memory");

endmodule
